### hdl/sorted_key_value_table_assert.svh
// Assertion macros for the sorted key/value table checkers.
// All macros sample on clk and are disabled while arst_n is low.
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Overlapping implication; the consequent may carry a constant delay.
`define SKVT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
	else $error("sorted key/value table check failed");

// Next-cycle implication.
`define SKVT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sorted key/value table check failed");

`endif

### hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Types, codes and sizes shared by the sorted key/value table modules.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int CAPACITY    = 64;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int COUNT_OUT_W = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DUP      = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [VAL_W-1:0]       value_out;
		logic [COUNT_OUT_W-1:0] count_after;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic cmp_en;
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

endpackage

### hdl/skvt_cell.sv
// ----------------------------------------------------------------------------
// skvt_cell
// One table slot: holds an entry, compares it against the command key and
// moves entries to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skvt_cell (
	input  logic                       clk,
	input  skvt_pkg::cell_ctrl_t       ctrl,
	input  logic                       in_use,
	input  logic [skvt_pkg::KEY_W-1:0] cmp_key,
	input  skvt_pkg::entry_t           new_entry,
	input  skvt_pkg::entry_t           prev_entry,
	input  logic                       prev_lt,
	input  skvt_pkg::entry_t           next_entry,
	output skvt_pkg::entry_t           entry,
	output logic                       lt,
	output logic                       eq,
	output logic [skvt_pkg::VAL_W-1:0] hit_value
);
	import skvt_pkg::*;

	entry_t entry_q;
	logic   lt_q;
	logic   eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= in_use && (entry_q.key < cmp_key);
			eq_q <= in_use && (entry_q.key == cmp_key);
		end
		if (ctrl.shift_up) begin
			// slots at or above the insert point move up; the first takes the new entry
			if (!lt_q) begin
				if (prev_lt) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (ctrl.shift_down) begin
			if (!lt_q) begin
				entry_q <= next_entry;
			end
		end
	end

	assign entry     = entry_q;
	assign lt        = lt_q;
	assign eq        = eq_q;
	assign hit_value = eq_q ? entry_q.value : '0;

endmodule

### hdl/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Ascending table of unique keys with values, held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd (opcode, key, value_in) with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   Opcodes: insert, remove, lookup; any other code is a no-op (not found).
//   Result channel: rsp (status, value_out, count_after) is valid for the
//   single cycle in which done is high. There is no back-pressure; the
//   receiver must take each result when it is shown.
//   Timing: the compare step follows the accepting edge, then the apply
//   step; done is registered from the apply step. The compare step compares
//   the key in every cell at once; the apply step shifts the cells by one
//   slot and registers the result. busy is high during the compare step only,
//   so a new command is taken while the previous one applies its shift.
//   Reset: arst_n clears the entry count and the control state; the table
//   reads as empty. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  skvt_pkg::cmd_t cmd,
	output logic           done,
	output skvt_pkg::rsp_t rsp
);
	import skvt_pkg::*;

	state_t           state_q;
	state_t           state_d;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             done_q;
	logic             accept;
	cell_ctrl_t       ctrl;
	logic             hit;
	logic             full;
	logic [VAL_W-1:0] hit_value_or;

	entry_t           entries   [CAPACITY];
	logic             lt_vec    [CAPACITY];
	logic             eq_vec    [CAPACITY];
	logic [VAL_W-1:0] hit_values[CAPACITY];
	entry_t           new_entry;

	assign busy      = (state_q == S_CMP);
	assign accept    = start && !busy;
	assign new_entry = '{key: cmd_q.key, value: cmd_q.value_in};

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   prev_l;
			logic   use_l;

			assign use_l = (CNT_W'(gi) < count_q);
			if (gi == 0) begin : g_first
				assign prev_e = '0;
				assign prev_l = 1'b1;
			end else begin : g_mid
				assign prev_e = entries[gi-1];
				assign prev_l = lt_vec[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign next_e = '0;
			end else begin : g_inner
				assign next_e = entries[gi+1];
			end

			skvt_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.in_use     (use_l),
				.cmp_key    (cmd_q.key),
				.new_entry  (new_entry),
				.prev_entry (prev_e),
				.prev_lt    (prev_l),
				.next_entry (next_e),
				.entry      (entries[gi]),
				.lt         (lt_vec[gi]),
				.eq         (eq_vec[gi]),
				.hit_value  (hit_values[gi])
			);
		end
	endgenerate

	always_comb begin
		hit          = 1'b0;
		hit_value_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit          = hit | eq_vec[i];
			hit_value_or = hit_value_or | hit_values[i];
		end
	end

	assign full = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= (state_q == S_APPLY);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == S_APPLY) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		ctrl            = '0;
		rsp_d.status    = ST_NOTFOUND;
		rsp_d.value_out = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = S_APPLY;
			end
			S_APPLY: begin
				case (cmd_q.opcode)
					OP_INSERT: begin
						if (hit) begin
							rsp_d.status = ST_DUP;
						end else if (full) begin
							rsp_d.status = ST_FULL;
						end else begin
							rsp_d.status  = ST_OK;
							ctrl.shift_up = 1'b1;
							count_d       = count_q + CNT_W'(1);
						end
					end
					OP_REMOVE: begin
						if (hit) begin
							rsp_d.status    = ST_OK;
							ctrl.shift_down = 1'b1;
							count_d         = count_q - CNT_W'(1);
						end
					end
					OP_LOOKUP: begin
						if (hit) begin
							rsp_d.status    = ST_OK;
							rsp_d.value_out = hit_value_or;
						end
					end
					default: begin
						rsp_d.status = ST_NOTFOUND;
					end
				endcase
				state_d = accept ? S_CMP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		rsp_d.count_after = COUNT_OUT_W'(count_d);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### hdl/skvt_checker.sv
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks on command timing and result fields of the table.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_assert.svh"

module skvt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input skvt_pkg::cmd_t cmd,
	input logic           done,
	input skvt_pkg::rsp_t rsp
);
	import skvt_pkg::*;

	logic accepted;
	logic cmd_known;

	assign accepted  = start && !busy;
	assign cmd_known = (cmd.opcode == OP_INSERT) || (cmd.opcode == OP_REMOVE)
		|| (cmd.opcode == OP_LOOKUP);

	`SKVT_ASSERT_NXT(a_busy_after_accept, accepted, busy)
	`SKVT_ASSERT_NXT(a_busy_one_cycle, busy, !busy)
	`SKVT_ASSERT_IMP(a_done_latency, accepted, ##3 done)
	`SKVT_ASSERT_IMP(a_value_zero_on_fail, done && (rsp.status != ST_OK), rsp.value_out == '0)
	`SKVT_ASSERT_IMP(a_bad_opcode_notfound, accepted && !cmd_known, ##3 (rsp.status == ST_NOTFOUND))

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (.*);
